// ===== hdl/rstab_pkg.sv =====
`timescale 1ns / 1ps
// rstab_pkg: shared types, constants and helpers of the ring successor table
// no dependencies; used by rstab_rem and ring_successor_table_top

package rstab_pkg;

  localparam int MAX_SLOTS_DEF = 512;
  localparam int ID_W          = 9;    // node id and key width
  localparam int SZ_W          = 10;   // ring size register width
  localparam int CFG_AW        = 2;    // apb address width
  localparam int CFG_DW        = 32;   // apb data width
  localparam int CNT_W         = 4;    // remainder step counter width

  localparam logic [SZ_W-1:0]   RING_SIZE_RST = 10'd512;
  localparam logic [CFG_AW-1:0] ADDR_RING_SIZE = 2'd0;

  localparam logic OP_JOIN   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] ident;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] owner;
    logic [ID_W-1:0] start_zero;
    logic [ID_W-1:0] node_zero;
    logic [ID_W-1:0] start_one;
    logic [ID_W-1:0] node_one;
    logic [ID_W-1:0] start_two;
    logic [ID_W-1:0] node_two;
    logic            bad_id;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_JOIN,
    ST_OWN,
    ST_DIV,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_DONE
  } state_t;

  // v + 1 modulo size, for v already below size
  function automatic logic [SZ_W-1:0] inc_wrap(input logic [SZ_W-1:0] v,
                                               input logic [SZ_W-1:0] size);
    logic [SZ_W:0] t;
    t = {1'b0, v} + {{SZ_W{1'b0}}, 1'b1};
    return (t == {1'b0, size}) ? '0 : t[SZ_W-1:0];
  endfunction

endpackage

// ===== hdl/rstab_chan_if.sv =====
`timescale 1ns / 1ps
// rstab_chan_if: valid/ready channel carrying one payload of type T
// payload types come from rstab_pkg

interface rstab_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rstab_ram.sv =====
`timescale 1ns / 1ps
// rstab_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module rstab_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rstab_rem.sv =====
`timescale 1ns / 1ps
// rstab_rem: restoring remainder unit, one quotient bit per cycle
// depends on rstab_pkg for widths

module rstab_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rstab_pkg::SZ_W-1:0] dividend,
  input  logic [rstab_pkg::SZ_W-1:0] divisor,
  output logic                       done,
  output logic [rstab_pkg::SZ_W-1:0] rem
);

  localparam int W = rstab_pkg::SZ_W;

  logic [W-1:0]                  dvd_r, dvd_nxt;
  logic [W-1:0]                  div_r, div_nxt;
  logic [W-1:0]                  rem_r, rem_nxt;
  logic [rstab_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [W:0]                    trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[W-1]};
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, div_r}) ? W'(trial - {1'b0, div_r}) : W'(trial);
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rstab_pkg::CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hdl/ring_successor_table_top.sv =====
`timescale 1ns / 1ps
// ring_successor_table_top: successor table of an identifier ring with finger lookup
// depends on rstab_pkg, rstab_chan_if, rstab_ram and rstab_rem
//
// Usage
//   in_chan (sink) takes a transaction {op, ident}: op join adds node ident to
//   the ring, op lookup returns the owner of key ident and three finger entries
//   (owner+1, +2, +4 modulo the ring size, each with its owner).
//   out_chan (source) gives one transaction per lookup and one per id at or
//   above the ring size (bad_id set, other fields zero); a good join gives none.
//   the apb port holds ring_size at address 0 (zero acts as 1, values above
//   MAX_SLOTS saturate); pready is always high.
// Timing
//   the owner table sits in one ram with a registered read; items are handled
//   one at a time. a lookup whose owner+1 reaches twice the ring size also
//   runs the ten-step remainder unit. a join walks the table slot by slot,
//   one ram read and write each.
//   a bad id skips the table and goes straight to its result.
//   after reset the ram is cleared, one entry a cycle, during which
//   in_chan.ready stays low; apb writes are taken throughout.
//   a stalled out_chan holds its result in the output register; the next item
//   is still accepted and worked on until its own result is ready.

module ring_successor_table_top #(
  parameter int MAX_SLOTS = rstab_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rstab_chan_if.sink                   in_chan,
  rstab_chan_if.source                 out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rstab_pkg::CFG_AW-1:0] paddr,
  input  logic [rstab_pkg::CFG_DW-1:0] pwdata,
  output logic [rstab_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);

  localparam int AW   = $clog2(MAX_SLOTS);
  localparam int ID_W = rstab_pkg::ID_W;
  localparam int SZ_W = rstab_pkg::SZ_W;

  rstab_pkg::state_t    state_r, state_nxt;
  logic [SZ_W-1:0]      ring_size_r;
  logic [SZ_W-1:0]      eff_size;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [ID_W-1:0]      node_r, node_nxt;
  logic [SZ_W-1:0]      s0_r, s0_nxt;
  logic [SZ_W-1:0]      s1_r, s1_nxt;
  logic [SZ_W-1:0]      s2_r, s2_nxt;
  rstab_pkg::out_item_t res_r, res_nxt;
  rstab_pkg::out_item_t out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ID_W-1:0]      ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ID_W-1:0]      ram_rdata;

  logic                 rem_start;
  logic [SZ_W-1:0]      rem_dividend;
  logic                 rem_done;
  logic [SZ_W-1:0]      rem_val;

  logic                 in_fire;
  logic                 cfg_wr;
  logic [SZ_W-1:0]      own_inc;
  logic [SZ_W-1:0]      own_sub;

  // configuration
  assign cfg_wr = psel && penable && pwrite && (paddr == rstab_pkg::ADDR_RING_SIZE);
  assign pready = 1'b1;
  assign prdata = (paddr == rstab_pkg::ADDR_RING_SIZE) ? rstab_pkg::CFG_DW'(ring_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= rstab_pkg::RING_SIZE_RST;
    end else if (cfg_wr) begin
      ring_size_r <= pwdata[SZ_W-1:0];
    end
  end

  always_comb begin
    if (ring_size_r == '0) begin
      eff_size = SZ_W'(1);
    end else if (32'(ring_size_r) > 32'(MAX_SLOTS)) begin
      eff_size = SZ_W'(MAX_SLOTS);
    end else begin
      eff_size = ring_size_r;
    end
  end

  rstab_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rstab_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (eff_size),
    .done     (rem_done),
    .rem      (rem_val)
  );

  assign in_chan.ready  = (state_r == rstab_pkg::ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // owner + 1 fits SZ_W since the owner is an id
  assign own_inc      = SZ_W'(ram_rdata) + SZ_W'(1);
  assign own_sub      = own_inc - eff_size;
  assign rem_dividend = own_inc;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    node_nxt      = node_r;
    s0_nxt        = s0_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = node_r;
    ram_raddr     = slot_r;
    rem_start     = 1'b0;

    case (state_r)
      rstab_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(MAX_SLOTS - 1)) begin
          state_nxt = rstab_pkg::ST_IDLE;
        end
      end
      rstab_pkg::ST_IDLE: begin
        ram_raddr = AW'(in_chan.data.ident);
        if (in_fire) begin
          slot_nxt = AW'(in_chan.data.ident);
          node_nxt = in_chan.data.ident;
          res_nxt  = '0;
          if ({1'b0, in_chan.data.ident} >= eff_size) begin
            res_nxt.bad_id = 1'b1;
            state_nxt      = rstab_pkg::ST_DONE;
          end else if (in_chan.data.op == rstab_pkg::OP_JOIN) begin
            state_nxt = rstab_pkg::ST_JOIN;
          end else begin
            state_nxt = rstab_pkg::ST_OWN;
          end
        end
      end
      rstab_pkg::ST_JOIN: begin
        // slot 0 always owns itself, so the walk ends there at the latest
        if (32'(ram_rdata) == 32'(slot_r)) begin
          state_nxt = rstab_pkg::ST_IDLE;
        end else begin
          ram_we    = 1'b1;
          slot_nxt  = (slot_r == '0) ? AW'(eff_size - SZ_W'(1)) : slot_r - 1'b1;
          ram_raddr = slot_nxt;
        end
      end
      rstab_pkg::ST_OWN: begin
        res_nxt.owner = ram_rdata;
        if (own_inc < eff_size) begin
          s0_nxt    = own_inc;
          state_nxt = rstab_pkg::ST_F0;
        end else if (own_sub < eff_size) begin
          s0_nxt    = own_sub;
          state_nxt = rstab_pkg::ST_F0;
        end else begin
          // table entry left over from a larger ring
          rem_start = 1'b1;
          state_nxt = rstab_pkg::ST_DIV;
        end
      end
      rstab_pkg::ST_DIV: begin
        if (rem_done) begin
          s0_nxt    = rem_val;
          state_nxt = rstab_pkg::ST_F0;
        end
      end
      rstab_pkg::ST_F0: begin
        ram_raddr          = AW'(s0_r);
        res_nxt.start_zero = s0_r[ID_W-1:0];
        s1_nxt             = rstab_pkg::inc_wrap(s0_r, eff_size);
        state_nxt          = rstab_pkg::ST_F1;
      end
      rstab_pkg::ST_F1: begin
        ram_raddr         = AW'(s1_r);
        res_nxt.node_zero = ram_rdata;
        res_nxt.start_one = s1_r[ID_W-1:0];
        s2_nxt            = rstab_pkg::inc_wrap(rstab_pkg::inc_wrap(s1_r, eff_size),
                                                eff_size);
        state_nxt         = rstab_pkg::ST_F2;
      end
      rstab_pkg::ST_F2: begin
        ram_raddr         = AW'(s2_r);
        res_nxt.node_one  = ram_rdata;
        res_nxt.start_two = s2_r[ID_W-1:0];
        state_nxt         = rstab_pkg::ST_F3;
      end
      rstab_pkg::ST_F3: begin
        res_nxt.node_two = ram_rdata;
        state_nxt        = rstab_pkg::ST_DONE;
      end
      rstab_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = rstab_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rstab_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rstab_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r     <= slot_nxt;
    node_r     <= node_nxt;
    s0_r       <= s0_nxt;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // table writes only come from the clearing pass or a join walk
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == rstab_pkg::ST_CLEAR || state_r == rstab_pkg::ST_JOIN))
    else $error("table written outside clear or join");

  // a join never overwrites slot 0, which must keep owning itself
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == rstab_pkg::ST_JOIN) |-> (ram_waddr != '0))
    else $error("join walk wrote slot 0");

  // a finished result never overwrites one still waiting at the output
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost");

  // the first finger start handed out lies inside the ring
  a_start_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rstab_pkg::ST_F0) |-> (s0_r < eff_size))
    else $error("finger start outside ring");

endmodule
